// File: design/cfc_pkg.sv
// Package for the command frame checker: types, codes and constants.
`default_nettype none
package cfc_pkg;

    // Register indexes on the configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FOOTER      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD = 2'd2;

    localparam logic [7:0] HEADER_RESET      = 8'h00;
    localparam logic [7:0] FOOTER_RESET      = 8'h00;
    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd57;

    // Check bytes are the held byte inverted
    localparam logic [7:0] CHECK_MASK = 8'hFF;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_DEST    = 3'd1,
        PH_TYPE    = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_TCHK    = 3'd5,
        PH_DCHK    = 3'd6,
        PH_FOOT    = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_LONG = 3'd1,
        ST_TYPE = 3'd2,
        ST_DEST = 3'd3,
        ST_FOOT = 3'd4
    } status_t;

    typedef struct packed {
        logic       is_frame_end;
        logic [7:0] payload_byte;
        logic [7:0] frame_dest;
        logic [7:0] frame_type;
        status_t    status;
    } result_t;

    // Handoff from the input register to the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_slot_t;

endpackage : cfc_pkg
`default_nettype wire

// File: design/cfc_byte_if.sv
// Byte stream channel interface.
`default_nettype none
interface cfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface : cfc_byte_if
`default_nettype wire

// File: design/cfc_result_if.sv
// Result channel interface: payload words and frame-end words.
`default_nettype none
interface cfc_result_if;
    logic       valid;
    logic       ready;
    logic       is_frame_end;
    logic [7:0] payload_byte;
    logic [7:0] frame_dest;
    logic [7:0] frame_type;
    logic [2:0] status;

    modport source (output valid, output is_frame_end, output payload_byte,
                    output frame_dest, output frame_type, output status, input ready);
    modport sink   (input valid, input is_frame_end, input payload_byte,
                    input frame_dest, input frame_type, input status, output ready);
endinterface : cfc_result_if
`default_nettype wire

// File: design/cfc_cfg_if.sv
// Configuration write channel interface.
`default_nettype none
interface cfc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : cfc_cfg_if
`default_nettype wire

// File: design/cfc_in_stage.sv
// Input register: holds one received byte until the parser takes it.
`default_nettype none
module cfc_in_stage
    import cfc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    cfc_byte_if.sink    bytes,
    input  wire logic   take,      // parser consumes the held byte this cycle
    output byte_slot_t  slot
);

    logic       valid_reg, valid_next;
    logic [7:0] data_reg;
    logic       load;

    assign bytes.ready = !valid_reg || take;
    assign load        = bytes.valid && bytes.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= bytes.in_byte;
    end

    assign slot.valid = valid_reg;
    assign slot.data  = data_reg;

endmodule : cfc_in_stage
`default_nettype wire

// File: design/cfc_parser.sv
// Frame parser: phase machine, held header fields and configuration registers.
`default_nettype none
module cfc_parser
    import cfc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    cfc_cfg_if.sink         cfg,
    input  wire byte_slot_t slot,
    input  wire logic       fire,      // slot byte is processed this cycle
    output logic            emit,
    output result_t         res
);

    logic [7:0] header_reg, footer_reg, max_payload_reg;
    phase_t     phase_reg, phase_next;
    logic [7:0] dest_reg, dest_next;
    logic [7:0] type_reg, type_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] seen_reg, seen_next;
    logic [7:0] seen_inc;
    logic [7:0] b;

    assign b         = slot.data;
    assign seen_inc  = seen_reg + 8'd1;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg      <= HEADER_RESET;
            footer_reg      <= FOOTER_RESET;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_HEADER:      header_reg      <= cfg.data;
                REG_FOOTER:      footer_reg      <= cfg.data;
                REG_MAX_PAYLOAD: max_payload_reg <= cfg.data;
                default:         ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        dest_next  = dest_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        if (fire)
        begin
            case (phase_reg)
                PH_HUNT:
                    if (b == header_reg)
                        phase_next = PH_DEST;
                PH_DEST:
                begin
                    dest_next  = b;
                    phase_next = PH_TYPE;
                end
                PH_TYPE:
                begin
                    type_next  = b;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    len_next  = b;
                    seen_next = 8'd0;
                    if (b > max_payload_reg)
                        phase_next = PH_HUNT;
                    else if (b == 8'd0)
                        phase_next = PH_TCHK;
                    else
                        phase_next = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    seen_next = seen_inc;
                    if (seen_inc >= len_reg)
                        phase_next = PH_TCHK;
                end
                PH_TCHK:
                    phase_next = (b == (type_reg ^ CHECK_MASK)) ? PH_DCHK : PH_HUNT;
                PH_DCHK:
                    phase_next = (b == (dest_reg ^ CHECK_MASK)) ? PH_FOOT : PH_HUNT;
                PH_FOOT:
                    phase_next = PH_HUNT;
                default:
                    phase_next = PH_HUNT;
            endcase
        end
    end

    // Result word
    always_comb
    begin
        emit             = 1'b0;
        res.is_frame_end = 1'b1;
        res.payload_byte = 8'd0;
        res.frame_dest   = dest_reg;
        res.frame_type   = type_reg;
        res.status       = ST_OK;
        if (fire)
        begin
            case (phase_reg)
                PH_LEN:
                    if (b > max_payload_reg)
                    begin
                        emit       = 1'b1;
                        res.status = ST_LONG;
                    end
                PH_PAYLOAD:
                begin
                    emit             = 1'b1;
                    res.is_frame_end = 1'b0;
                    res.payload_byte = b;
                end
                PH_TCHK:
                    if (b != (type_reg ^ CHECK_MASK))
                    begin
                        emit       = 1'b1;
                        res.status = ST_TYPE;
                    end
                PH_DCHK:
                    if (b != (dest_reg ^ CHECK_MASK))
                    begin
                        emit       = 1'b1;
                        res.status = ST_DEST;
                    end
                PH_FOOT:
                begin
                    emit       = 1'b1;
                    res.status = (b == footer_reg) ? ST_OK : ST_FOOT;
                end
                default:
                    emit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            dest_reg  <= 8'd0;
            type_reg  <= 8'd0;
            len_reg   <= 8'd0;
            seen_reg  <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            dest_reg  <= dest_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
        end
    end

endmodule : cfc_parser
`default_nettype wire

// File: design/cfc_out_stage.sv
// Result register: holds one result word until the consumer takes it.
`default_nettype none
module cfc_out_stage
    import cfc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t res,
    output logic         space,    // a word can be loaded this cycle
    cfc_result_if.source results
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign space = !valid_reg || results.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (space)
            valid_next = load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (space && load)
            res_reg <= res;
    end

    assign results.valid        = valid_reg;
    assign results.is_frame_end = res_reg.is_frame_end;
    assign results.payload_byte = res_reg.payload_byte;
    assign results.frame_dest   = res_reg.frame_dest;
    assign results.frame_type   = res_reg.frame_type;
    assign results.status       = res_reg.status;

endmodule : cfc_out_stage
`default_nettype wire

// File: design/command_frame_checker.sv
// Top level of the command frame checker.
`default_nettype none
// Command frame checker. Bytes enter on the bytes channel one word per
// cycle; the block hunts for the header byte, then takes dest, type and
// length, passes each of the length payload bytes out as a payload word
// (is_frame_end = 0), checks the inverted type, the inverted dest and the
// footer, and closes the frame with one frame-end word (is_frame_end = 1)
// carrying dest, type and status (0 ok, 1 length over max_payload, 2 type
// check bad, 3 dest check bad, 4 footer bad). The first failed check ends
// the frame; that byte is dropped and hunting restarts with the next byte.
// On a bad status the consumer discards payload already passed out.
// Throughput is one byte per cycle unless the results channel stalls: a
// byte is held in the input register, the parser handles it with 8-bit
// compares, and any result is registered in the output register, which
// presents it to the consumer. Backpressure on the results channel stalls
// input only when the output register is full and not being taken. The
// cfg port is always ready; write only while idle. Index 0 header,
// 1 footer, 2 max_payload (reset 0, 0, 57); index 3 is ignored.
module command_frame_checker
    import cfc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    cfc_byte_if.sink     bytes,
    cfc_result_if.source results,
    cfc_cfg_if.sink      cfg
);

    byte_slot_t slot;
    result_t    res;
    logic       emit;
    logic       space;
    logic       fire;

    // Parser advances whenever a byte is held and the result register can
    // take a word, whether or not this byte yields one.
    assign fire = slot.valid && space;

    cfc_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (bytes),
        .take  (fire),
        .slot  (slot)
    );

    cfc_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .slot  (slot),
        .fire  (fire),
        .emit  (emit),
        .res   (res)
    );

    cfc_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (emit),
        .res     (res),
        .space   (space),
        .results (results)
    );

`ifndef NO_ASSERTIONS
    // A payload word never carries an error status.
    a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.is_frame_end |-> results.status == ST_OK)
        else $error("payload word with nonzero status");

    // Input stalls only behind a held byte that cannot advance.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !bytes.ready |-> slot.valid && !space)
        else $error("input stalled without cause");

    // A result is only produced when the parser consumes a byte.
    a_emit_fire: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> fire)
        else $error("result produced without a byte");

    // A loaded word shows up on the results channel next cycle.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit && space |=> results.valid)
        else $error("loaded result not presented");
`endif

endmodule : command_frame_checker
`default_nettype wire
